// ===== sv/token_argument_splitter_defines.svh =====
// assertion helpers for the argument splitter
// both forms sample on i_clk and are held off while i_rst_n is low
`ifndef TOKEN_ARGUMENT_SPLITTER_DEFINES_SVH
`define TOKEN_ARGUMENT_SPLITTER_DEFINES_SVH

// consequence must hold in the same cycle
`define TAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define TAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tas_pkg.sv =====
`timescale 1ns / 1ps
package tas_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEFAULT = 32;
    localparam int INDEX_BITS_DEFAULT  = 16;

    // result queue
    localparam int FIFO_DEPTH = 4;

    // token classes
    localparam logic [3:0] CLS_OTHER  = 4'd0;
    localparam logic [3:0] CLS_TRIVIA = 4'd1;
    localparam logic [3:0] CLS_LPAREN = 4'd2;
    localparam logic [3:0] CLS_LBRACK = 4'd3;
    localparam logic [3:0] CLS_LBRACE = 4'd4;
    localparam logic [3:0] CLS_RPAREN = 4'd5;
    localparam logic [3:0] CLS_RBRACK = 4'd6;
    localparam logic [3:0] CLS_RBRACE = 4'd7;
    localparam logic [3:0] CLS_COMMA  = 4'd8;
    localparam logic [3:0] CLS_EOF    = 4'd9;

    // expected closer codes held on the stack
    localparam logic [1:0] CLOSE_PAREN = 2'd0;
    localparam logic [1:0] CLOSE_BRACK = 2'd1;
    localparam logic [1:0] CLOSE_BRACE = 2'd2;

    // list status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISMATCH  = 2'd1;
    localparam logic [1:0] ST_UNCLOSED  = 2'd2;
    localparam logic [1:0] ST_TOO_DEEP  = 2'd3;

    // shift command broadcast along the stack cells
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] closer;
    } t_stack_op;

    // results written into the queue together in the same cycle
    typedef struct packed {
        logic first;
        logic second;
    } t_fifo_push;

endpackage

// ===== sv/tas_cell.sv =====
`timescale 1ns / 1ps
module tas_cell (
    input  logic              i_clk,
    input  tas_pkg::t_stack_op i_op,
    input  logic [1:0]        i_above,
    input  logic [1:0]        i_below,
    output logic [1:0]        o_value
);
    import tas_pkg::*;

    logic [1:0] r_value;

    // push takes the neighbour nearer the top, pop takes the one further down
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_value <= i_above;
        end else if (i_op.pop) begin
            r_value <= i_below;
        end
    end

    assign o_value = r_value;

endmodule

// ===== sv/tas_fifo.sv =====
`timescale 1ns / 1ps
module tas_fifo #(
    parameter int WIDTH = 38
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tas_pkg::t_fifo_push i_push,
    input  logic [WIDTH-1:0]   i_data0,
    input  logic [WIDTH-1:0]   i_data1,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WIDTH-1:0]   o_data
);
    import tas_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_q [FIFO_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] w_tail_next;
    logic [CNT_W-1:0] w_push_cnt;
    logic             w_pop;

    assign w_tail_next = PTR_W'(r_tail + 1'b1);
    assign w_push_cnt  = CNT_W'({1'b0, i_push.first}) + CNT_W'({1'b0, i_push.second});
    assign w_pop       = o_valid && !i_stall;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= PTR_W'(r_head + PTR_W'(w_pop));
            r_tail  <= PTR_W'(r_tail + PTR_W'(w_push_cnt));
            r_count <= CNT_W'(r_count + w_push_cnt - CNT_W'(w_pop));
        end
    end

    // storage, up to two entries written per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_q[r_tail] <= i_data0;
        end
        if (i_push.second) begin
            r_q[w_tail_next] <= i_data1;
        end
    end

    // space for two results keeps the producer free to write a pair
    assign o_room  = r_count <= CNT_W'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_q[r_head];

endmodule

// ===== sv/token_argument_splitter.sv =====
`timescale 1ns / 1ps
// a token's results are registered into the result queue at its transfer and offered in order from its head
// throughput: one token per cycle while o_stall is low; the nesting check is a single shift of the closer cell row
// a comma that is also the last token gives two results through a four-entry result queue
// o_stall rises while that queue holds more than two results
// reset is synchronous on i_rst_n low: list state and queue clear, stack cells keep no reset
module token_argument_splitter #(
    parameter int STACK_DEPTH = tas_pkg::STACK_DEPTH_DEFAULT,
    parameter int INDEX_BITS  = tas_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [INDEX_BITS-1:0] i_token_index,
    input  logic [3:0]            i_token_class,
    input  logic                  i_last_token,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [INDEX_BITS:0]   o_arg_begin,
    output logic [INDEX_BITS:0]   o_arg_end,
    output logic                  o_arg_present,
    output logic [1:0]            o_status,
    output logic                  o_list_done
);
    import tas_pkg::*;
    `include "token_argument_splitter_defines.svh"

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int RES_W = 2 * (INDEX_BITS + 1) + 4;

    logic [LVL_W-1:0]      r_level,  n_level;
    logic [INDEX_BITS-1:0] r_first,  n_first;
    logic [INDEX_BITS:0]   r_end,    n_end;
    logic                  r_has,    n_has;
    logic                  r_comma,  n_comma;
    logic [1:0]            r_err,    n_err;

    logic                  w_acc;
    logic                  w_drop;
    logic                  w_active;
    logic                  w_is_open;
    logic                  w_is_close;
    logic                  w_comma_fire;
    logic [INDEX_BITS:0]   w_idx_ext;
    logic [INDEX_BITS:0]   w_idx_inc;
    logic [1:0]            w_top;
    logic [1:0]            w_open_code;
    logic [1:0]            w_close_code;
    t_stack_op             w_op;
    t_fifo_push            w_push;
    logic                  w_room;

    logic [INDEX_BITS:0]   w_c_begin, w_c_end;
    logic [INDEX_BITS:0]   w_f_begin, w_f_end, w_list_end;
    logic                  w_f_present;
    logic [1:0]            w_f_status;
    logic [RES_W-1:0]      w_comma_res, w_final_res, w_res0, w_out;
    logic [1:0]            w_cell [STACK_DEPTH];

    assign w_acc        = i_valid && !o_stall;
    assign w_drop       = i_last_token && (i_token_class == CLS_EOF);
    assign w_active     = w_acc && !w_drop && (r_err == ST_OK);
    assign w_is_open    = (i_token_class == CLS_LPAREN) || (i_token_class == CLS_LBRACK)
                       || (i_token_class == CLS_LBRACE);
    assign w_is_close   = (i_token_class == CLS_RPAREN) || (i_token_class == CLS_RBRACK)
                       || (i_token_class == CLS_RBRACE);
    assign w_idx_ext    = {1'b0, i_token_index};
    assign w_idx_inc    = (INDEX_BITS + 1)'(w_idx_ext + 1'b1);
    assign w_open_code  = 2'(i_token_class - CLS_LPAREN);
    assign w_close_code = 2'(i_token_class - CLS_RPAREN);
    assign w_top        = w_cell[0];

    // argument closed by a comma at depth zero
    assign w_c_begin = r_has ? {1'b0, r_first} : w_idx_ext;
    assign w_c_end   = r_has ? r_end : w_idx_ext;

    // token decode, nesting update and final result
    always_comb begin
        n_level      = r_level;
        n_first      = r_first;
        n_end        = r_end;
        n_has        = r_has;
        n_comma      = r_comma;
        n_err        = r_err;
        w_op         = '0;
        w_comma_fire = 1'b0;

        if (w_active && (i_token_class != CLS_TRIVIA)) begin
            if ((i_token_class == CLS_COMMA) && (r_level == '0)) begin
                w_comma_fire = 1'b1;
                n_has        = 1'b0;
                n_comma      = 1'b1;
            end else begin
                if (!r_has) begin
                    n_first = i_token_index;
                end
                n_has = 1'b1;
                n_end = w_idx_inc;
                if (w_is_open) begin
                    if (r_level == LVL_W'(STACK_DEPTH)) begin
                        n_err = ST_TOO_DEEP;
                    end else begin
                        w_op.push   = 1'b1;
                        w_op.closer = w_open_code;
                        n_level     = LVL_W'(r_level + 1'b1);
                    end
                end else if (w_is_close) begin
                    if ((r_level == '0) || (w_top != w_close_code)) begin
                        n_err = ST_MISMATCH;
                    end else begin
                        w_op.pop = 1'b1;
                        n_level  = LVL_W'(r_level - 1'b1);
                    end
                end
            end
        end

        // final result from the state after this token
        w_list_end  = w_drop ? w_idx_ext : w_idx_inc;
        w_f_status  = ((n_err == ST_OK) && (n_level != '0)) ? ST_UNCLOSED : n_err;
        w_f_begin   = '0;
        w_f_end     = '0;
        w_f_present = 1'b0;
        if (w_f_status == ST_OK) begin
            if (n_has) begin
                w_f_begin   = {1'b0, n_first};
                w_f_end     = n_end;
                w_f_present = 1'b1;
            end else if (n_comma) begin
                w_f_begin   = w_list_end;
                w_f_end     = w_list_end;
                w_f_present = 1'b1;
            end
        end

        // list ends: back to the empty state
        if (w_acc && i_last_token) begin
            n_level = '0;
            n_first = '0;
            n_end   = '0;
            n_has   = 1'b0;
            n_comma = 1'b0;
            n_err   = ST_OK;
        end
    end

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_first <= '0;
            r_end   <= '0;
            r_has   <= 1'b0;
            r_comma <= 1'b0;
            r_err   <= ST_OK;
        end else begin
            r_level <= n_level;
            r_first <= n_first;
            r_end   <= n_end;
            r_has   <= n_has;
            r_comma <= n_comma;
            r_err   <= n_err;
        end
    end

    // closer stack as a row of shifting cells, top at cell zero
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [1:0] w_above;
        logic [1:0] w_below;
        if (g == 0) begin : g_top
            assign w_above = w_op.closer;
        end else begin : g_mid
            assign w_above = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_below = CLOSE_PAREN;
        end else begin : g_up
            assign w_below = w_cell[g+1];
        end
        tas_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_above (w_above),
            .i_below (w_below),
            .o_value (w_cell[g])
        );
    end

    // results into the queue, comma result ahead of the final one
    assign w_comma_res  = {w_c_begin, w_c_end, 1'b1, ST_OK, 1'b0};
    assign w_final_res  = {w_f_begin, w_f_end, w_f_present, w_f_status, 1'b1};
    assign w_push.first = w_comma_fire || (w_acc && i_last_token);
    assign w_push.second = w_comma_fire && w_acc && i_last_token;
    assign w_res0       = w_comma_fire ? w_comma_res : w_final_res;

    tas_fifo #(
        .WIDTH (RES_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data0 (w_res0),
        .i_data1 (w_final_res),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_stall = !w_room;
    assign {o_arg_begin, o_arg_end, o_arg_present, o_status, o_list_done} = w_out;

    // checks
    `TAS_ASSERT_NOW(a_err_final, o_valid && (o_status != ST_OK),
        o_list_done && !o_arg_present, "error status outside a final result")
    `TAS_ASSERT_NOW(a_level_bound, 1'b1, r_level <= LVL_W'(STACK_DEPTH),
        "nesting level beyond stack depth")
    `TAS_ASSERT_NEXT(a_list_clear, w_acc && i_last_token,
        (r_level == '0) && !r_has && !r_comma && (r_err == ST_OK),
        "list state not cleared after last token")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import tas_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TOKEN_COUNT = 950;

    typedef struct packed {
        logic [15:0] idx;
        logic [3:0]  cls;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [16:0] first_idx;
        logic [16:0] end_idx;
        logic        present;
        logic [1:0]  status;
        logic        done;
    } t_arg_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_token_index;
    logic [3:0]  i_token_class;
    logic        i_last_token;
    logic        o_valid;
    logic        i_stall;
    logic [16:0] o_arg_begin;
    logic [16:0] o_arg_end;
    logic        o_arg_present;
    logic [1:0]  o_status;
    logic        o_list_done;

    t_token      pending_tokens[$];
    t_arg_result expected_args[$];
    logic [15:0] next_idx;

    // splitter state as the predictor sees it
    logic [1:0]  closer_stack [0:STACK_DEPTH_DEFAULT-1];
    int          nest_level;
    logic [16:0] first_solid;
    logic [16:0] solid_end;
    logic        has_solid;
    logic        comma_seen;
    logic [1:0]  list_status;

    bit          tok_taken;
    int          tokens_taken;
    int          mismatches;
    int          cycles;
    int          send_gap;
    int          stall_left;
    bit          stall_on;
    int          hold_left;
    int          holds_done;

    token_argument_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_token_index (i_token_index),
        .i_token_class (i_token_class),
        .i_last_token  (i_last_token),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_arg_begin   (o_arg_begin),
        .o_arg_end     (o_arg_end),
        .o_arg_present (o_arg_present),
        .o_status      (o_status),
        .o_list_done   (o_list_done)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // closer code for either bracket of a pair
    function automatic logic [1:0] closer_for(input logic [3:0] cls);
        case (cls) inside
            CLS_LPAREN, CLS_RPAREN: closer_for = CLOSE_PAREN;
            CLS_LBRACK, CLS_RBRACK: closer_for = CLOSE_BRACK;
            default:                closer_for = CLOSE_BRACE;
        endcase
    endfunction

    // predict the arguments and list status caused by one token
    task automatic track_token(input logic [15:0] idx, input logic [3:0] cls,
                               input logic last);
        logic        drop;
        logic [16:0] list_end;
        t_arg_result r;
        drop = last && (cls == CLS_EOF);
        r = '0;
        if (!drop && list_status == ST_OK) begin
            if (cls == CLS_TRIVIA) begin
                // trivia leaves the bounds alone
            end else if (cls == CLS_COMMA && nest_level == 0) begin
                r.first_idx = has_solid ? first_solid : {1'b0, idx};
                r.end_idx   = has_solid ? solid_end : {1'b0, idx};
                r.present   = 1'b1;
                expected_args.push_back(r);
                has_solid  = 1'b0;
                comma_seen = 1'b1;
            end else begin
                if (!has_solid) first_solid = {1'b0, idx};
                has_solid = 1'b1;
                solid_end = {1'b0, idx} + 17'd1;
                if (cls == CLS_LPAREN || cls == CLS_LBRACK || cls == CLS_LBRACE) begin
                    if (nest_level >= STACK_DEPTH_DEFAULT) begin
                        list_status = ST_TOO_DEEP;
                    end else begin
                        closer_stack[nest_level] = closer_for(cls);
                        nest_level++;
                    end
                end else if (cls == CLS_RPAREN || cls == CLS_RBRACK ||
                             cls == CLS_RBRACE) begin
                    if (nest_level == 0 ||
                        closer_stack[nest_level-1] != closer_for(cls)) begin
                        list_status = ST_MISMATCH;
                    end else begin
                        nest_level--;
                    end
                end
            end
        end
        // final result of the list, then back to a clean list
        if (last) begin
            list_end = drop ? {1'b0, idx} : {1'b0, idx} + 17'd1;
            if (list_status == ST_OK && nest_level != 0) list_status = ST_UNCLOSED;
            r = '0;
            r.done = 1'b1;
            if (list_status != ST_OK) begin
                r.status = list_status;
            end else if (has_solid) begin
                r.first_idx = first_solid;
                r.end_idx   = solid_end;
                r.present   = 1'b1;
            end else if (comma_seen) begin
                r.first_idx = list_end;
                r.end_idx   = list_end;
                r.present   = 1'b1;
            end
            expected_args.push_back(r);
            nest_level  = 0;
            first_solid = '0;
            solid_end   = '0;
            has_solid   = 1'b0;
            comma_seen  = 1'b0;
            list_status = ST_OK;
        end
    endtask

    // queue one token at the running index
    task automatic put_tok(input logic [3:0] cls, input logic last);
        t_token t;
        t.idx  = next_idx;
        t.cls  = cls;
        t.last = last;
        pending_tokens.push_back(t);
        next_idx = next_idx + 16'd1;
    endtask

    // a list nested to the given depth and then closed again
    task automatic put_nested_list(input int depth);
        logic [3:0] closers[$];
        for (int k = 0; k < depth; k++) begin
            case ($urandom_range(0, 2))
                0: begin put_tok(CLS_LPAREN, 1'b0); closers.push_back(CLS_RPAREN); end
                1: begin put_tok(CLS_LBRACK, 1'b0); closers.push_back(CLS_RBRACK); end
                default: begin
                    put_tok(CLS_LBRACE, 1'b0);
                    closers.push_back(CLS_RBRACE);
                end
            endcase
        end
        put_tok(CLS_OTHER, 1'b0);
        while (closers.size() != 0) put_tok(closers.pop_back(), 1'b0);
        put_tok(CLS_EOF, 1'b1);
    endtask

    // stimulus, reset and end of run
    initial begin
        logic [3:0] closers[$];
        logic [3:0] end_cls;
        int         shape;
        int         len;
        int         pick;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_token_index = '0;
        i_token_class = CLS_OTHER;
        i_last_token  = 1'b0;
        i_stall       = 1'b0;
        nest_level    = 0;
        first_solid   = '0;
        solid_end     = '0;
        has_solid     = 1'b0;
        comma_seen    = 1'b0;
        list_status   = ST_OK;

        // empty list sent as a lone eof
        next_idx = 16'h0000;
        put_tok(CLS_EOF, 1'b1);
        // single token at the top index, end wraps into bit 16
        next_idx = 16'hFFFF;
        put_tok(CLS_OTHER, 1'b1);
        // all-trivia arguments either side of a comma, trailing eof dropped
        next_idx = 16'h00FF;
        put_tok(CLS_TRIVIA, 1'b0);
        put_tok(CLS_COMMA, 1'b0);
        put_tok(CLS_TRIVIA, 1'b0);
        put_tok(CLS_EOF, 1'b1);
        // every bracket kind properly nested
        next_idx = 16'h8000;
        put_tok(CLS_LPAREN, 1'b0);
        put_tok(CLS_LBRACK, 1'b0);
        put_tok(CLS_LBRACE, 1'b0);
        put_tok(CLS_RBRACE, 1'b0);
        put_tok(CLS_RBRACK, 1'b0);
        put_tok(CLS_RPAREN, 1'b0);
        put_tok(CLS_COMMA, 1'b0);
        put_tok(CLS_OTHER, 1'b1);
        // mismatched closer
        put_tok(CLS_LPAREN, 1'b0);
        put_tok(CLS_RBRACK, 1'b1);
        // unclosed opener
        put_tok(CLS_LBRACK, 1'b0);
        put_tok(CLS_OTHER, 1'b1);
        // comma as the last token gives two results
        next_idx = 16'h7FFE;
        put_tok(CLS_OTHER, 1'b0);
        put_tok(CLS_COMMA, 1'b1);
        // eof that is not last, and an unused class code
        put_tok(CLS_EOF, 1'b0);
        put_tok(4'd15, 1'b1);
        // early error, later tokens ignored
        put_tok(CLS_RBRACE, 1'b0);
        put_tok(CLS_COMMA, 1'b0);
        put_tok(CLS_OTHER, 1'b1);

        // full stack, then one opener too many
        next_idx = 16'($urandom);
        put_nested_list(STACK_DEPTH_DEFAULT);
        next_idx = 16'($urandom);
        put_nested_list(STACK_DEPTH_DEFAULT + 1);

        // random lists, mostly well formed
        while (pending_tokens.size() < TOKEN_COUNT) begin
            shape    = $urandom_range(0, 99);
            next_idx = 16'($urandom);
            if (shape < 70) begin
                len = $urandom_range(0, 12);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (closers.size() != 0 && pick < 25) begin
                        put_tok(closers.pop_back(), 1'b0);
                    end else if (pick < 45 && closers.size() < 6) begin
                        case ($urandom_range(0, 2))
                            0: begin
                                put_tok(CLS_LPAREN, 1'b0);
                                closers.push_back(CLS_RPAREN);
                            end
                            1: begin
                                put_tok(CLS_LBRACK, 1'b0);
                                closers.push_back(CLS_RBRACK);
                            end
                            default: begin
                                put_tok(CLS_LBRACE, 1'b0);
                                closers.push_back(CLS_RBRACE);
                            end
                        endcase
                    end else if (pick < 60) begin
                        put_tok(CLS_COMMA, 1'b0);
                    end else if (pick < 75) begin
                        put_tok(CLS_TRIVIA, 1'b0);
                    end else if (pick < 80) begin
                        put_tok(CLS_EOF, 1'b0);
                    end else if (pick < 85) begin
                        put_tok(4'($urandom_range(10, 15)), 1'b0);
                    end else begin
                        put_tok(CLS_OTHER, 1'b0);
                    end
                end
                while (closers.size() != 0) put_tok(closers.pop_back(), 1'b0);
                case ($urandom_range(0, 4))
                    0, 1: end_cls = CLS_EOF;
                    2:    end_cls = CLS_COMMA;
                    3:    end_cls = CLS_TRIVIA;
                    default: end_cls = CLS_OTHER;
                endcase
                put_tok(end_cls, 1'b1);
            end else if (shape < 73) begin
                put_nested_list($urandom_range(1, STACK_DEPTH_DEFAULT + 2));
            end else begin
                // noise and broken lists
                len = $urandom_range(0, 9);
                for (int k = 0; k < len; k++) put_tok(4'($urandom_range(0, 15)), 1'b0);
                put_tok(4'($urandom_range(0, 15)), 1'b1);
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // drain: every token sent and every result seen
        while (pending_tokens.size() != 0 || i_valid || expected_args.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_args.size() == 0) begin
            $display("token_argument_splitter test passed");
        end else begin
            $display("token_argument_splitter test failed");
        end
        $finish;
    end

    // token driver, new transfer offered at the falling edge
    always @(negedge i_clk) begin
        t_token t;
        int     pick;
        if (!i_rst_n) begin
            // hold inputs quiet in reset
        end else if (i_valid && !tok_taken) begin
            // stalled payload stays put
        end else if (send_gap != 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (pending_tokens.size() != 0) begin
            t = pending_tokens.pop_front();
            i_valid       <= 1'b1;
            i_token_index <= t.idx;
            i_token_class <= t.cls;
            i_last_token  <= t.last;
            pick = $urandom_range(0, 99);
            if (pick < 60)      send_gap = 0;
            else if (pick < 93) send_gap = $urandom_range(1, 3);
            else                send_gap = $urandom_range(10, 40);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // long receiver hold-off, twice during the run
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && tokens_taken >= 300 * (holds_done + 1)) begin
            hold_left  <= 150;
            holds_done <= holds_done + 1;
        end
    end

    // random receiver stalls
    always @(negedge i_clk) begin
        int pick;
        if (stall_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                stall_on   = 1'b0;
                stall_left = $urandom_range(1, 6);
            end else if (pick < 60) begin
                stall_on   = 1'b0;
                stall_left = $urandom_range(20, 80);
            end else if (pick < 92) begin
                stall_on   = 1'b1;
                stall_left = $urandom_range(1, 3);
            end else begin
                stall_on   = 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
        stall_left--;
        i_stall <= stall_on || (hold_left != 0);
    end

    // result check and prediction at the rising edge
    always @(posedge i_clk) begin
        t_arg_result got;
        t_arg_result want;
        if (!i_rst_n) begin
            tok_taken = 1'b0;
        end else begin
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("token_argument_splitter test failed");
                $finish;
            end
            if (o_valid && !i_stall) begin
                got = {o_arg_begin, o_arg_end, o_arg_present, o_status, o_list_done};
                if (expected_args.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected result transfer: ",
                                  "begin %0d end %0d present %0b status %0d done %0b"},
                                 got.first_idx, got.end_idx, got.present, got.status,
                                 got.done);
                end else begin
                    want = expected_args.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: begin %0d/%0d end %0d/%0d ",
                                      "present %0b/%0b status %0d/%0d done %0b/%0b ",
                                      "(expected/actual)"},
                                     want.first_idx, got.first_idx, want.end_idx,
                                     got.end_idx, want.present, got.present,
                                     want.status, got.status, want.done, got.done);
                    end
                end
            end
            tok_taken = i_valid && !o_stall;
            if (tok_taken) begin
                tokens_taken++;
                track_token(i_token_index, i_token_class, i_last_token);
            end
        end
    end

endmodule
